### design/prt_pkg.sv
// prt_pkg: shared types and constants for the prescaled reload down timer
// used by prt_core and prescaled_reload_down_timer; no dependencies
`default_nettype none

package prt_pkg;

	typedef enum logic [2:0] {
		KIND_READ_COUNT   = 3'd0,
		KIND_READ_ENABLE  = 3'd1,
		KIND_WRITE_RELOAD = 3'd2,
		KIND_WRITE_ENABLE = 3'd3,
		KIND_ADVANCE      = 3'd4
	} kind_t;

	localparam logic [11:0] PERIOD_RESET = 12'd3072;
	localparam logic [15:0] LEFT_RESET   = 16'd3072;
	localparam logic [6:0]  UFLOW_COUNT  = 7'h7F;
	localparam logic signed [17:0] SAT_LOW = -18'sd32768;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  write_data;
		logic [7:0]  bus_latch;
		logic [11:0] cycle_count;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
	} result_t;

endpackage

`default_nettype wire

### design/prt_core.sv
// prt_core: timer state, prescale period register and the per-item update
// depends on prt_pkg
`default_nettype none

module prt_core
	import prt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata,
	input  wire logic        step_en,
	input  wire item_t       item,
	output result_t          res
);

	logic [11:0]        period_q;
	logic [6:0]         count_q;
	logic [6:0]         reload_q;
	logic               enable_q;
	logic               uflow_q;
	logic signed [15:0] left_q;

	logic [6:0]         count_d;
	logic [6:0]         reload_d;
	logic               enable_d;
	logic               uflow_d;
	logic signed [15:0] left_d;

	logic signed [17:0] left_ext;
	logic signed [17:0] cyc_ext;
	logic signed [17:0] cyc_adj;
	logic signed [17:0] base;
	logic signed [17:0] diff;
	logic               tick;

	always_comb begin
		count_d   = count_q;
		reload_d  = reload_q;
		enable_d  = enable_q;
		uflow_d   = uflow_q;
		left_d    = left_q;
		res.read_data = item.bus_latch;
		res.irq   = 1'b0;
		left_ext  = {{2{left_q[15]}}, left_q};
		cyc_ext   = {6'd0, item.cycle_count};
		cyc_adj   = cyc_ext;
		base      = left_ext;
		tick      = 1'b0;
		diff      = '0;
		case (item.kind)
			KIND_READ_COUNT: begin
				if (uflow_q) begin
					uflow_d = 1'b0;
					res.read_data = {item.bus_latch[7], UFLOW_COUNT};
				end else begin
					res.read_data = {item.bus_latch[7], count_q};
				end
			end
			KIND_READ_ENABLE: begin
				res.read_data = {item.bus_latch[7:1], enable_q};
			end
			KIND_WRITE_RELOAD: begin
				res.read_data = item.write_data;
				reload_d = item.write_data[6:0];
			end
			KIND_WRITE_ENABLE: begin
				res.read_data = item.write_data;
				if (!enable_q)
					count_d = reload_q;
				enable_d = item.write_data[0];
			end
			KIND_ADVANCE: begin
				if (left_ext < cyc_ext) begin
					// a zero remainder does not shorten the elapsed cycles
					if (left_q != '0)
						cyc_adj = cyc_ext - left_ext;
					base = {6'd0, period_q};
					tick = 1'b1;
				end
				diff = base - cyc_adj;
				if (diff < SAT_LOW)
					left_d = SAT_LOW[15:0];
				else
					left_d = diff[15:0];
				if (tick && enable_q) begin
					if (count_q == '0) begin
						uflow_d = 1'b1;
						count_d = reload_q;
						res.irq = 1'b1;
					end else begin
						count_d = count_q - 7'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
			count_q  <= '0;
			reload_q <= '0;
			enable_q <= 1'b0;
			uflow_q  <= 1'b0;
			left_q   <= LEFT_RESET;
		end else begin
			if (cfg_we)
				period_q <= cfg_wdata;
			if (step_en) begin
				count_q  <= count_d;
				reload_q <= reload_d;
				enable_q <= enable_d;
				uflow_q  <= uflow_d;
				left_q   <= left_d;
			end
		end
	end

	a_irq_only_advance: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.irq |-> item.kind == KIND_ADVANCE)
		else $error("irq raised by a bus access");

	a_irq_reloads: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.irq |=> count_q == $past(reload_q))
		else $error("underflow did not reload the counter");

	a_irq_arms_flag: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.irq |=> uflow_q)
		else $error("underflow did not arm the read flag");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> count_q == $past(count_q) && left_q == $past(left_q))
		else $error("timer state moved without an item");

endmodule

`default_nettype wire

### design/prescaled_reload_down_timer.sv
// prescaled_reload_down_timer: a 7-bit down timer with reload, enable,
// cycle prescaler and underflow interrupt, as bus accesses and advances.
// Channels: input item on s_t*, result on m_t*, one result per item.
//   s_tuser: kind. s_tdata: write_data, bus_latch, cycle_count (low first).
//   m_tdata: read_data, irq (low first).
// Config: cfg_we/cfg_wdata load the prescale period (cycles between ticks)
//   and do not touch the running prescale count; write only while idle.
// Pipeline: an accepted item is registered in the input register, then
//   processed into the output register once that is free, and m_tvalid
//   rises with the result held there until it is taken.
// Throughput: one item per clock while m_tready is high; the state update is
//   a single pass of logic between the input and result registers.
// Reset (arst_n low): counter, reload, enable and underflow flag clear,
//   period and prescale count return to 3072, both registers empty.
// Stall: while m_tready is low the result holds, the input register keeps
//   one more item, and s_tready drops once both are full.
`default_nettype none

module prescaled_reload_down_timer
	import prt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [11:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // write_data[7:0], bus_latch[15:8], cycle_count[27:16]
	input  wire logic [2:0]  s_tuser,  // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata   // read_data[7:0], irq[8]
);

	logic    s1_valid_q;
	item_t   item_s1;
	logic    out_valid_q;
	result_t out_q;
	result_t res;
	logic    out_free;
	logic    step_en;

	assign out_free = !out_valid_q || m_tready;
	assign step_en  = s1_valid_q && out_free;
	assign s_tready = !s1_valid_q || step_en;

	prt_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step_en   (step_en),
		.item      (item_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready)
				s1_valid_q <= s_tvalid;
			if (out_free)
				out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind        <= s_tuser;
			item_s1.write_data  <= s_tdata[7:0];
			item_s1.bus_latch   <= s_tdata[15:8];
			item_s1.cycle_count <= s_tdata[27:16];
		end
		if (step_en)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.irq, out_q.read_data};

	a_stalled_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q)
		else $error("input register dropped an item during a stall");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> s_tready)
		else $error("input refused with an empty input register");

	a_step_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		step_en |=> out_valid_q)
		else $error("processed item did not reach the output register");

endmodule

`default_nettype wire
